@@ hdl/fae_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fae_pkg;

  localparam int unsigned PageBytesDef      = 256;
  localparam int unsigned NumPagesDef       = 1024;
  localparam int unsigned SubsectorBytesDef = 4096;
  localparam int unsigned NumArraysDef      = 2;

  localparam logic [7:0] Erased = 8'hFF;

  typedef enum logic [1:0] {
    OpRead     = 2'd0,
    OpProgram  = 2'd1,
    OpEraseSub = 2'd2,
    OpEraseAll = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        array_sel;
    logic [9:0]  page;
    logic [7:0]  start_offset;
    logic [8:0]  burst_length;
    logic [7:0]  data;
    logic [17:0] byte_address;
    logic [5:0]  subsector;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
    logic       burst_done;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/flash_array_emulator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Flash array emulator: NUM_ARRAYS byte arrays of NUM_PAGES * PAGE_BYTES bytes.
// Command channel: an item is taken at a clock edge with start_i high and
// busy_o low. Each item gives exactly one result on result_o, marked by a
// one-cycle valid_o strobe; the receiver takes it in that cycle and cannot stall.
// Read and program items go through the address and memory access states, and
// the result is registered on leaving the access state; no new item is taken
// before the block is back in idle as its result shows. Programs do a
// read-modify-write on the single memory port (new cell = old cell AND data).
// Rejected items, erases among them, take the same path. Erases sweep their
// bytes one per cycle through the same port: a subsector erase sweeps
// SUBSECTOR_BYTES bytes, a whole-array erase NUM_PAGES * PAGE_BYTES bytes.
// After reset a clearing pass writes 0xFF to every byte, one byte a cycle,
// NUM_ARRAYS * NUM_PAGES * PAGE_BYTES bytes in all, with busy_o high throughout.
// A shared burst counter picks the byte within a read or program burst.

module flash_array_emulator #(
  parameter int unsigned PAGE_BYTES      = fae_pkg::PageBytesDef,
  parameter int unsigned NUM_PAGES       = fae_pkg::NumPagesDef,
  parameter int unsigned SUBSECTOR_BYTES = fae_pkg::SubsectorBytesDef,
  parameter int unsigned NUM_ARRAYS      = fae_pkg::NumArraysDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire fae_pkg::item_t   item_i,
  output logic                  busy_o,
  output logic                  valid_o,
  output fae_pkg::result_t      result_o
);

  localparam int unsigned ArrayBytes    = NUM_PAGES * PAGE_BYTES;
  localparam int unsigned TotalBytes    = NUM_ARRAYS * ArrayBytes;
  localparam int unsigned NumSubsectors = ArrayBytes / SUBSECTOR_BYTES;
  localparam int unsigned MemAw         = $clog2(TotalBytes);

  typedef enum logic [4:0] {
    StClear  = 5'b00001,
    StIdle   = 5'b00010,
    StAddr   = 5'b00100,
    StAccess = 5'b01000,
    StErase  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [8:0]             cnt_q, cnt_d;
  logic                   valid_q, valid_d;
  fae_pkg::result_t       res_q, res_d;
  fae_pkg::op_e           op_q, op_d;
  logic                   ok_q, ok_d;
  logic                   done_q, done_d;
  logic                   sel_q, sel_d;
  logic [7:0]             data_q, data_d;
  logic [MemAw-1:0]       loc_q, loc_d;
  logic [MemAw-1:0]       span_q, span_d;
  logic [MemAw-1:0]       ptr_q, ptr_d;
  logic [MemAw-1:0]       end_q, end_d;
  logic [7:0]             rdata_q;

  logic [7:0]             mem_q [TotalBytes];
  logic                   mem_we, mem_re;
  logic [7:0]             mem_wdata;
  logic [MemAw-1:0]       base, acc_addr;

  logic                   accept;
  logic                   arr_ok, len_ok, cnt_lt, burst_end;
  logic                   prog_ok, rd_ok, sub_ok;
  logic [31:0]            loc_full;

  assign accept = start_i && (state_q == StIdle);

  // Per-item checks and in-array offset, taken at accept
  always_comb begin
    arr_ok    = 32'(item_i.array_sel) < NUM_ARRAYS;
    len_ok    = item_i.burst_length != 9'd0;
    cnt_lt    = cnt_q < item_i.burst_length;
    burst_end = !len_ok || ({1'b0, cnt_q} + 10'd1 >= {1'b0, item_i.burst_length});
    prog_ok   = arr_ok && len_ok && cnt_lt
                && (32'(item_i.page) < NUM_PAGES)
                && (32'(item_i.burst_length) <= PAGE_BYTES)
                && (32'(item_i.start_offset) + 32'(item_i.burst_length) <= PAGE_BYTES);
    rd_ok     = arr_ok && len_ok && cnt_lt
                && (32'(item_i.byte_address) + 32'(item_i.burst_length) <= ArrayBytes);
    sub_ok    = arr_ok && ((item_i.op == fae_pkg::OpEraseAll)
                || (32'(item_i.subsector) < NumSubsectors));
    unique case (item_i.op)
      fae_pkg::OpRead:     loc_full = 32'(item_i.byte_address) + 32'(cnt_q);
      fae_pkg::OpProgram:  loc_full = 32'(item_i.page) * PAGE_BYTES
                                      + 32'(item_i.start_offset) + 32'(cnt_q);
      fae_pkg::OpEraseSub: loc_full = 32'(item_i.subsector) * SUBSECTOR_BYTES;
      fae_pkg::OpEraseAll: loc_full = 32'd0;
      default:             loc_full = 32'd0;
    endcase
  end

  assign base     = sel_q ? MemAw'(ArrayBytes) : '0;
  assign acc_addr = base + loc_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    res_d   = res_q;
    op_d    = op_q;
    ok_d    = ok_q;
    done_d  = done_q;
    sel_d   = sel_q;
    data_d  = data_q;
    loc_d   = loc_q;
    span_d  = span_q;
    ptr_d   = ptr_q;
    end_d   = end_q;
    mem_re  = 1'b0;
    unique case (state_q)
      StClear: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == MemAw'(TotalBytes - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          op_d   = item_i.op;
          sel_d  = item_i.array_sel;
          data_d = item_i.data;
          loc_d  = MemAw'(loc_full);
          span_d = (item_i.op == fae_pkg::OpEraseAll) ? MemAw'(ArrayBytes - 1)
                                                      : MemAw'(SUBSECTOR_BYTES - 1);
          unique case (item_i.op)
            fae_pkg::OpRead: begin
              ok_d   = rd_ok;
              done_d = burst_end;
              cnt_d  = burst_end ? 9'd0 : cnt_q + 9'd1;
            end
            fae_pkg::OpProgram: begin
              ok_d   = prog_ok;
              done_d = burst_end;
              cnt_d  = burst_end ? 9'd0 : cnt_q + 9'd1;
            end
            default: begin
              ok_d   = sub_ok;
              done_d = 1'b1;
              cnt_d  = 9'd0;
            end
          endcase
          state_d = StAddr;
        end
      end
      StAddr: begin
        ptr_d  = acc_addr;
        end_d  = acc_addr + span_q;
        mem_re = ok_q && ((op_q == fae_pkg::OpRead) || (op_q == fae_pkg::OpProgram));
        if (ok_q && ((op_q == fae_pkg::OpEraseSub) || (op_q == fae_pkg::OpEraseAll))) begin
          state_d = StErase;
        end else begin
          state_d = StAccess;
        end
      end
      StAccess: begin
        valid_d            = 1'b1;
        res_d.read_data    = (ok_q && (op_q == fae_pkg::OpRead)) ? rdata_q : 8'd0;
        res_d.status       = !ok_q;
        res_d.burst_done   = done_q;
        state_d            = StIdle;
      end
      StErase: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == end_q) begin
          valid_d          = 1'b1;
          res_d.read_data  = 8'd0;
          res_d.status     = 1'b0;
          res_d.burst_done = 1'b1;
          state_d          = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Single memory port: sweeps write 0xFF, program writes old AND data
  always_comb begin
    mem_we    = (state_q == StClear) || (state_q == StErase)
                || ((state_q == StAccess) && ok_q && (op_q == fae_pkg::OpProgram));
    mem_wdata = (state_q == StAccess) ? (rdata_q & data_q) : fae_pkg::Erased;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[ptr_q] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[acc_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cnt_q   <= 9'd0;
      valid_q <= 1'b0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    op_q   <= op_d;
    ok_q   <= ok_d;
    done_q <= done_d;
    sel_q  <= sel_d;
    data_q <= data_d;
    loc_q  <= loc_d;
    span_q <= span_d;
    end_q  <= end_d;
  end

  assign busy_o   = (state_q != StIdle);
  assign valid_o  = valid_q;
  assign result_o = res_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after taking an item");

  a_read_only_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (result_o.read_data != 8'd0)) |-> !result_o.status)
    else $error("read data on a rejected item");

  a_erase_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StErase) |-> (ptr_q <= end_q))
    else $error("erase sweep ran past its range");

  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_result_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("results closer than the access sequence allows");

endmodule

`default_nettype wire

@@ test/flash_result_checker.sv @@
`timescale 1ns / 1ps

module flash_result_checker
  import fae_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    busy_i,
  input  item_t   item_i,
  input  logic    valid_i,
  input  result_t result_i,
  output int      mismatches_o,
  output int      awaited_o,
  output int      checked_o
);

  localparam int unsigned ArrayBytes    = NumPagesDef * PageBytesDef;
  localparam int unsigned NumSubsectors = ArrayBytes / SubsectorBytesDef;
  localparam int unsigned TotalBytes    = NumArraysDef * ArrayBytes;

  logic [7:0] cell_image [TotalBytes];
  logic [8:0] burst_pos;
  result_t    awaited_results [$];
  int         mismatch_cnt = 0;
  int         pending_cnt = 0;
  int         checked_cnt = 0;

  assign mismatches_o = mismatch_cnt;
  assign awaited_o    = pending_cnt;
  assign checked_o    = checked_cnt;

  initial begin
    for (int unsigned i = 0; i < TotalBytes; i++) cell_image[i] = Erased;
    burst_pos = '0;
  end

  function automatic void wipe(int unsigned first, int unsigned count);
    for (int unsigned i = 0; i < count; i++) cell_image[first + i] = Erased;
  endfunction

  // Apply one item to the cell image and return the result it must give.
  function automatic result_t predict_access(item_t it);
    result_t     res;
    int unsigned base;
    int unsigned cnt;
    int unsigned len;
    int unsigned addr;
    logic        in_range;
    logic        ok;
    logic        done;
    res      = '0;
    in_range = int'(it.array_sel) < NumArraysDef;
    base     = it.array_sel * ArrayBytes;
    if (it.op == OpEraseSub || it.op == OpEraseAll) begin
      res.status = 1'b1;
      if (in_range) begin
        if (it.op == OpEraseAll) begin
          wipe(base, ArrayBytes);
          res.status = 1'b0;
        end else if (it.subsector < NumSubsectors) begin
          wipe(base + it.subsector * SubsectorBytesDef, SubsectorBytesDef);
          res.status = 1'b0;
        end
      end
      // an erase always ends whatever burst was running
      burst_pos      = '0;
      res.burst_done = 1'b1;
      return res;
    end
    cnt  = burst_pos;
    len  = it.burst_length;
    ok   = in_range && len >= 1 && cnt < len;
    done = (len == 0) || (cnt + 1 >= len);
    if (it.op == OpProgram) begin
      ok = ok && it.page < NumPagesDef && len <= PageBytesDef
           && it.start_offset + len <= PageBytesDef;
      if (ok) begin
        addr = base + it.page * PageBytesDef + it.start_offset + cnt;
        cell_image[addr] = cell_image[addr] & it.data;
      end
    end else begin
      ok = ok && it.byte_address + len <= ArrayBytes;
      if (ok) res.read_data = cell_image[base + it.byte_address + cnt];
    end
    burst_pos      = done ? 9'd0 : 9'(cnt + 1);
    res.status     = !ok;
    res.burst_done = done;
    return res;
  endfunction

  task automatic report(string field, int want, int got);
    if (mismatch_cnt < 100)
      $display("mismatch on %s: expected %0h, got %0h (result %0d, %0t)",
               field, want, got, checked_cnt, $realtime);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      // compare before taking a new item: the result belongs to an older one
      if (valid_i) begin
        if (awaited_results.size() == 0) begin
          report("unrequested result", 0, result_i);
        end else begin
          want = awaited_results.pop_front();
          if (result_i.read_data !== want.read_data)
            report("read_data", want.read_data, result_i.read_data);
          if (result_i.status !== want.status)
            report("status", want.status, result_i.status);
          if (result_i.burst_done !== want.burst_done)
            report("burst_done", want.burst_done, result_i.burst_done);
          checked_cnt++;
        end
      end
      if (start_i && !busy_i) awaited_results.push_back(predict_access(item_i));
      pending_cnt = awaited_results.size();
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import fae_pkg::*;

  // clearing pass, one whole-array erase, a few dozen subsector erases, slack
  localparam int Limit = 4_000_000;
  localparam int unsigned ArrayBytes = NumPagesDef * PageBytesDef;

  logic    clk_i;
  logic    rst_ni;
  logic    start_i;
  item_t   item_i;
  logic    busy_o;
  logic    valid_o;
  result_t result_o;

  int mismatches;
  int awaited;
  int checked;
  int cycles = 0;
  int sent = 0;
  int reads = 0;
  int programs = 0;
  int erases = 0;
  int run_left = 0;
  int target;

  flash_array_emulator dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  flash_result_checker result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .item_i       (item_i),
    .valid_i      (valid_o),
    .result_i     (result_o),
    .mismatches_o (mismatches),
    .awaited_o    (awaited),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= Limit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, awaited);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic item_t any_item();
    logic [$bits(item_t)-1:0] raw;
    raw = $bits(item_t)'({$urandom, $urandom});
    return item_t'(raw);
  endfunction

  task automatic pause(int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      item_i  <= any_item();
    end
  endtask

  // Present one item and hold it until taken; idle between runs of items.
  task automatic send(item_t it);
    @(negedge clk_i);
    item_i  <= it;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    sent++;
    case (it.op)
      OpRead:    reads++;
      OpProgram: programs++;
      default:   erases++;
    endcase
    if (run_left > 0) begin
      run_left--;
    end else begin
      pause($urandom_range(1, 8));
      run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) : $urandom_range(0, 10);
    end
  endtask

  // where: read start address, page * PAGE_BYTES + offset for a program,
  // subsector index for a subsector erase
  task automatic send_op(op_e op, logic sel, int unsigned len, int unsigned where,
                         logic [7:0] value);
    item_t it;
    it              = any_item();
    it.op           = op;
    it.array_sel    = sel;
    it.burst_length = 9'(len);
    it.data         = value;
    case (op)
      OpRead:     it.byte_address = 18'(where);
      OpProgram:  {it.page, it.start_offset} = 18'(where);
      OpEraseSub: it.subsector = 6'(where);
      default: ;
    endcase
    send(it);
  endtask

  // Most traffic lands in the first and last subsector so reads see programs.
  function automatic int unsigned pick_page();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 15);
      4, 5, 6:    return $urandom_range(NumPagesDef - 16, NumPagesDef - 1);
      default:    return $urandom_range(0, NumPagesDef - 1);
    endcase
  endfunction

  task automatic send_erase();
    int unsigned sub;
    case ($urandom_range(0, 4))
      0, 1:    sub = 0;
      2, 3:    sub = 63;
      default: sub = $urandom_range(0, 63);
    endcase
    send_op(OpEraseSub, 1'($urandom), $urandom, sub, 8'($urandom));
  endtask

  task automatic send_noise();
    item_t it;
    it    = any_item();
    it.op = it.op[0] ? OpProgram : OpRead;
    send(it);
  endtask

  // A well-formed burst with random bytes; now and then cut short.
  task automatic run_burst();
    op_e         op;
    logic        sel;
    int unsigned len;
    int unsigned where;
    int unsigned cut;
    op  = $urandom_range(0, 1) ? OpProgram : OpRead;
    sel = 1'($urandom);
    case ($urandom_range(0, 19))
      0:       len = $urandom_range(200, PageBytesDef);
      1, 2:    len = $urandom_range(9, 32);
      default: len = $urandom_range(1, 8);
    endcase
    if (op == OpProgram) begin
      where = pick_page() * PageBytesDef + $urandom_range(0, PageBytesDef - len);
    end else begin
      where = pick_page() * PageBytesDef + $urandom_range(0, PageBytesDef - 1);
      if (where + len > ArrayBytes) where = ArrayBytes - len;
    end
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
    for (int unsigned i = 0; i < cut; i++) send_op(op, sel, len, where, 8'($urandom));
    if (cut < len) begin
      if ($urandom_range(0, 1)) send_erase();
      else send_noise();
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    item_i  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_op(OpRead, 1'b0, 1, 0, 8'h00);
    send_op(OpProgram, 1'b1, 1, (NumPagesDef - 1) * PageBytesDef + 255, 8'h00);
    send_op(OpRead, 1'b1, 1, ArrayBytes - 1, 8'hFF);
    // read that runs past the array end: whole burst rejected
    repeat (2) send_op(OpRead, 1'b1, 2, ArrayBytes - 1, 8'h00);
    // program that runs past the page end
    repeat (2) send_op(OpProgram, 1'b0, 2, 255, 8'hFF);
    send_op(OpProgram, 1'b0, 0, 0, 8'h00);
    send_op(OpRead, 1'b0, 0, 0, 8'h00);
    // over-long program, then the length shrinks below the counter
    send_op(OpProgram, 1'b0, 257, 0, 8'h00);
    send_op(OpProgram, 1'b0, 1, 0, 8'h00);
    // erase lands in the middle of a program burst
    send_op(OpProgram, 1'b0, 3, 0, 8'h0F);
    send_op(OpProgram, 1'b0, 3, 0, 8'h3C);
    send_op(OpEraseSub, 1'b0, 0, 0, 8'h00);
    send_op(OpProgram, 1'b0, 2, 0, 8'h0F);
    send_op(OpProgram, 1'b0, 2, 0, 8'hF0);
    repeat (2) send_op(OpRead, 1'b0, 2, 0, 8'h00);
    send_op(OpEraseSub, 1'b1, 0, 63, 8'h00);
    send_op(OpRead, 1'b1, 1, ArrayBytes - 1, 8'h00);
    send_op(OpProgram, 1'b1, 1, 5 * PageBytesDef + 7, 8'h81);
    send_op(OpRead, 1'b1, 511, 0, 8'h00);
    send_op(OpEraseAll, 1'b1, 0, 0, 8'h00);
    send_op(OpRead, 1'b1, 1, 5 * PageBytesDef + 7, 8'h00);
    send_op(OpRead, 1'b1, 511, ArrayBytes - 1, 8'h00);
    send_op(OpRead, 1'b1, 0, 0, 8'h00);

    // hold off until the block has drained
    @(negedge clk_i);
    start_i <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
    run_left = 0;

    target = sent + 1550;
    while (sent < target) begin
      case ($urandom_range(0, 99)) inside
        [0:79]:  run_burst();
        [80:87]: send_erase();
        default: send_noise();
      endcase
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("run: %0d items (%0d reads, %0d programs, %0d erases), %0d results checked",
             sent, reads, programs, erases, checked);
    $display("run: %0d mismatches, %0d results outstanding", mismatches, awaited);
    if (mismatches == 0 && awaited == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/fae_pkg.sv
hdl/flash_array_emulator.sv
test/flash_result_checker.sv
test/testbench.sv
